[design/dttm_pkg.sv]
// Shared types, constants and helpers for the duration text parser.
`timescale 1ns / 1ps

package dttm_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned FieldW = 20;
  localparam int unsigned SumW   = 32;
  localparam int unsigned FracW  = 10;
  localparam int unsigned DurW   = 32;

  // Parser phases.
  localparam logic [1:0] PhaseInt  = 2'd0;
  localparam logic [1:0] PhaseFrac = 2'd1;
  localparam logic [1:0] PhaseDone = 2'd2;

  // Fraction digit places.
  localparam logic [1:0] PlaceHundreds = 2'd0;
  localparam logic [1:0] PlaceTens     = 2'd1;
  localparam logic [1:0] PlaceOnes     = 2'd2;
  localparam logic [1:0] PlaceFull     = 2'd3;

  localparam logic [1:0] MaxColons = 2'd2;

  localparam logic [FieldW-1:0] FieldLimit = 20'd100000;

  localparam logic [CharW-1:0] CharNul   = 8'h00;
  localparam logic [CharW-1:0] CharDot   = 8'h2E;
  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharNine  = 8'h39;
  localparam logic [CharW-1:0] CharColon = 8'h3A;

  typedef struct packed {
    logic [FieldW-1:0] field_value;
    logic [SumW-1:0]   seconds_sum;
    logic [1:0]        colon_count;
    logic              digit_seen;
    logic [1:0]        phase;
    logic [FracW-1:0]  fraction_ms;
    logic [1:0]        fraction_place;
    logic              failed;
  } parse_state_t;

  typedef struct packed {
    logic              failed;
    logic [SumW-1:0]   seconds;
    logic [FracW-1:0]  fraction_ms;
  } parse_result_t;

  localparam parse_state_t StateReset = '{
    field_value:    '0,
    seconds_sum:    '0,
    colon_count:    '0,
    digit_seen:     1'b0,
    phase:          PhaseInt,
    fraction_ms:    '0,
    fraction_place: PlaceHundreds,
    failed:         1'b0
  };

  function automatic logic [FracW-1:0] place_weight(input logic [1:0] place);
    logic [FracW-1:0] w;
    unique case (place)
      PlaceHundreds: w = 10'd100;
      PlaceTens:     w = 10'd10;
      PlaceOnes:     w = 10'd1;
      default:       w = 10'd0;
    endcase
    return w;
  endfunction

endpackage

[design/dttm_step.sv]
// Per-character update of the parser state and the final value on the last character.
`timescale 1ns / 1ps

module dttm_step (
  input  dttm_pkg::parse_state_t         state_i,
  input  logic [dttm_pkg::CharW-1:0]     char_i,
  output dttm_pkg::parse_state_t         state_o,
  output dttm_pkg::parse_result_t        result_o
);

  logic                         is_digit;
  logic [3:0]                   digit;
  logic [dttm_pkg::SumW-1:0]    fold_old;
  logic [dttm_pkg::SumW-1:0]    fold_new;
  dttm_pkg::parse_state_t       nxt;

  assign is_digit = (char_i >= dttm_pkg::CharZero) && (char_i <= dttm_pkg::CharNine);
  assign digit    = is_digit ? 4'(char_i - dttm_pkg::CharZero) : 4'd0;

  // Seconds folded with the field as it stood before and after this character.
  assign fold_old = 32'(state_i.seconds_sum * 32'd60) + 32'(state_i.field_value);
  assign fold_new = 32'(state_i.seconds_sum * 32'd60) + 32'(nxt.field_value);

  always_comb begin
    nxt = state_i;
    if (!state_i.failed) begin
      unique case (state_i.phase)
        dttm_pkg::PhaseInt: begin
          priority if (is_digit) begin
            if (state_i.field_value > dttm_pkg::FieldLimit) begin
              nxt.failed = 1'b1;
            end else begin
              nxt.field_value = 20'(state_i.field_value * 20'd10) + 20'(digit);
              nxt.digit_seen  = 1'b1;
            end
          end else if (char_i == dttm_pkg::CharColon) begin
            if (state_i.colon_count >= dttm_pkg::MaxColons) begin
              nxt.failed = 1'b1;
            end else begin
              nxt.seconds_sum = fold_old;
              nxt.field_value = '0;
              nxt.digit_seen  = 1'b0;
              nxt.colon_count = state_i.colon_count + 2'd1;
            end
          end else if (char_i == dttm_pkg::CharDot || char_i == dttm_pkg::CharNul) begin
            if (!state_i.digit_seen) begin
              nxt.failed = 1'b1;
            end else begin
              nxt.seconds_sum = fold_old;
            end
            nxt.phase = (char_i == dttm_pkg::CharDot) ? dttm_pkg::PhaseFrac
                                                      : dttm_pkg::PhaseDone;
          end else begin
            nxt.failed = 1'b1;
          end
        end
        dttm_pkg::PhaseFrac: begin
          if (is_digit && state_i.fraction_place != dttm_pkg::PlaceFull) begin
            nxt.fraction_ms = state_i.fraction_ms
                            + 10'(10'(digit) * dttm_pkg::place_weight(state_i.fraction_place));
            nxt.fraction_place = state_i.fraction_place + 2'd1;
          end else begin
            nxt.phase = dttm_pkg::PhaseDone;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign state_o = nxt;

  // When the text ends still inside the integer part, the open field is folded in here.
  always_comb begin
    result_o.fraction_ms = nxt.fraction_ms;
    if (!nxt.failed && nxt.phase == dttm_pkg::PhaseInt) begin
      result_o.failed  = !nxt.digit_seen;
      result_o.seconds = fold_new;
    end else begin
      result_o.failed  = nxt.failed;
      result_o.seconds = nxt.seconds_sum;
    end
  end

endmodule

[design/duration_text_to_milliseconds_unit.sv]
// Top level of the duration text to milliseconds converter.
//
// The input channel carries one character of a duration text per transaction
// (character_i, with last_i marking the final character). Texts such as
// H:MM:SS.fff, MM:SS or bare seconds are accepted; a zero byte ends the text.
// The output channel carries one transaction per text, on its last character:
// total_ms_o in milliseconds, or 0 for malformed text, wrapping modulo 2^32.
// Transactions on both channels complete on a rising edge where valid is high
// and stall is low.
// Throughput is one character per cycle unless the receiver stalls.
// The pipeline has three registers: the input register, the parser state
// with the result register, and the output register holding the final
// multiply by 1000, from which out_valid_o and total_ms_o are driven.
// When the receiver stalls, the pipeline compacts bubbles and then holds;
// in_stall_o rises only once every stage is occupied.
// Reset empties the pipeline and returns the parser to the start of a text.
`timescale 1ns / 1ps

module duration_text_to_milliseconds_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [dttm_pkg::CharW-1:0]    character_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [dttm_pkg::DurW-1:0]     total_ms_o
);

  logic                         in_valid_q;
  logic [dttm_pkg::CharW-1:0]   in_char_q;
  logic                         in_last_q;

  dttm_pkg::parse_state_t       state_q;
  dttm_pkg::parse_state_t       state_d;
  dttm_pkg::parse_result_t      step_result;

  logic                         res_valid_q;
  dttm_pkg::parse_result_t      res_q;

  logic                         out_valid_q;
  logic [dttm_pkg::DurW-1:0]    duration_q;
  logic [dttm_pkg::DurW-1:0]    duration_d;

  logic                         en_out;
  logic                         en_res;
  logic                         en_in;

  assign en_out     = !out_valid_q || !out_stall_i;
  assign en_res     = !res_valid_q || en_out;
  assign en_in      = !in_valid_q || en_res;
  assign in_stall_o = !en_in;

  dttm_step u_step (
    .state_i  (state_q),
    .char_i   (in_char_q),
    .state_o  (state_d),
    .result_o (step_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (en_in) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_in && in_valid_i) begin
      in_char_q <= character_i;
      in_last_q <= last_i;
    end
  end

  // The parser state moves on when the character leaves the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dttm_pkg::StateReset;
      res_valid_q <= 1'b0;
    end else if (en_res) begin
      res_valid_q <= in_valid_q && in_last_q;
      if (in_valid_q) begin
        state_q <= in_last_q ? dttm_pkg::StateReset : state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_res && in_valid_q && in_last_q) begin
      res_q <= step_result;
    end
  end

  assign duration_d = res_q.failed ? '0
                    : 32'(res_q.seconds * 32'd1000) + 32'(res_q.fraction_ms);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_out) begin
      out_valid_q <= res_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out && res_valid_q) begin
      duration_q <= duration_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign total_ms_o  = duration_q;

endmodule

[tb/dttm_duration_checker.sv]
// Checker that predicts and compares the milliseconds produced for each duration text.
`timescale 1ns / 1ps

module dttm_duration_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic [dttm_pkg::CharW-1:0] character_i,
  input  logic                       last_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic [dttm_pkg::DurW-1:0]  total_ms_i,
  output int unsigned                mismatches_o,
  output int unsigned                pending_o
);

  localparam logic [dttm_pkg::SumW-1:0] FoldBase = 32'd60;
  localparam logic [dttm_pkg::DurW-1:0] MsPerSec = 32'd1000;

  // Running parse of the text seen so far.
  logic [dttm_pkg::FieldW-1:0] field_val;
  logic [dttm_pkg::SumW-1:0]   sec_sum;
  logic [1:0]                  colons;
  logic                        seen_digit;
  logic [1:0]                  phase;
  logic [dttm_pkg::FracW-1:0]  frac;
  logic [1:0]                  place;
  logic                        bad;

  logic [dttm_pkg::DurW-1:0]   expected_ms[$];
  logic [dttm_pkg::DurW-1:0]   want_ms;
  int unsigned                 mismatch_cnt = 0;
  int unsigned                 result_cnt = 0;

  assign mismatches_o = mismatch_cnt;

  task automatic report(input string msg);
    $display("%0t ns: duration mismatch: %s", $time, msg);
    mismatch_cnt++;
  endtask

  task automatic clear_text();
    field_val  = '0;
    sec_sum    = '0;
    colons     = '0;
    seen_digit = 1'b0;
    phase      = dttm_pkg::PhaseInt;
    frac       = '0;
    place      = dttm_pkg::PlaceHundreds;
    bad        = 1'b0;
  endtask

  // Closing the integer part needs at least one digit since the last colon.
  task automatic close_field();
    if (!seen_digit) begin
      bad = 1'b1;
    end else begin
      sec_sum = sec_sum * FoldBase + dttm_pkg::SumW'(field_val);
    end
  endtask

  task automatic parse_char(input logic [dttm_pkg::CharW-1:0] ch, input logic fin);
    logic                       is_digit;
    logic [3:0]                 digit;
    logic [dttm_pkg::FracW-1:0] weight;
    is_digit = (ch >= dttm_pkg::CharZero) && (ch <= dttm_pkg::CharNine);
    digit    = is_digit ? 4'(ch - dttm_pkg::CharZero) : 4'd0;
    if (!bad) begin
      unique case (phase)
        dttm_pkg::PhaseInt: begin
          if (is_digit) begin
            if (field_val > dttm_pkg::FieldLimit) begin
              bad = 1'b1;
            end else begin
              field_val  = field_val * 20'd10 + dttm_pkg::FieldW'(digit);
              seen_digit = 1'b1;
            end
          end else if (ch == dttm_pkg::CharColon) begin
            if (colons >= dttm_pkg::MaxColons) begin
              bad = 1'b1;
            end else begin
              sec_sum    = sec_sum * FoldBase + dttm_pkg::SumW'(field_val);
              field_val  = '0;
              seen_digit = 1'b0;
              colons     = colons + 2'd1;
            end
          end else if (ch == dttm_pkg::CharDot) begin
            close_field();
            phase = dttm_pkg::PhaseFrac;
          end else if (ch == dttm_pkg::CharNul) begin
            close_field();
            phase = dttm_pkg::PhaseDone;
          end else begin
            bad = 1'b1;
          end
        end
        dttm_pkg::PhaseFrac: begin
          if (is_digit && place != dttm_pkg::PlaceFull) begin
            weight = (place == dttm_pkg::PlaceHundreds) ? 10'd100 :
                     (place == dttm_pkg::PlaceTens)     ? 10'd10  : 10'd1;
            frac   = frac + dttm_pkg::FracW'(digit) * weight;
            place  = place + 2'd1;
          end else begin
            phase = dttm_pkg::PhaseDone;
          end
        end
        default: begin
        end
      endcase
    end
    if (fin) begin
      if (!bad && phase == dttm_pkg::PhaseInt) begin
        close_field();
      end
      expected_ms.push_back(bad ? '0 : sec_sum * MsPerSec + dttm_pkg::DurW'(frac));
      clear_text();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_text();
      expected_ms.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        result_cnt++;
        if (expected_ms.size() == 0) begin
          report($sformatf("result %0d: got %0d with nothing outstanding",
                           result_cnt, total_ms_i));
        end else begin
          want_ms = expected_ms.pop_front();
          if (total_ms_i !== want_ms) begin
            report($sformatf("result %0d: total_ms got %0d, want %0d",
                             result_cnt, total_ms_i, want_ms));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        parse_char(character_i, last_i);
      end
      pending_o <= expected_ms.size();
    end
  end

endmodule

[tb/tb.sv]
// Testbench top: clock, reset, text stimulus, receiver stalls and the final verdict.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned TargetChars   = 1100;
  localparam int unsigned WatchdogLimit = 2000;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [dttm_pkg::CharW-1:0] character = '0;
  logic                       last = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [dttm_pkg::DurW-1:0]  total_ms;

  int unsigned       mismatches;
  int unsigned       pending;
  int unsigned       quiet_cycles = 0;
  int unsigned       sent_chars = 0;
  int unsigned       burst_left = 0;
  int unsigned       stall_left = 0;
  int unsigned       stall_mode = 0;

  logic [dttm_pkg::CharW-1:0] text_q[$];

  always #10 clk = ~clk;

  duration_text_to_milliseconds_unit u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .character_i   (character),
    .last_i        (last),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .total_ms_o    (total_ms)
  );

  dttm_duration_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .character_i   (character),
    .last_i        (last),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .total_ms_i    (total_ms),
    .mismatches_o  (mismatches),
    .pending_o     (pending)
  );

  // The receiver switches between free running, light, heavy and periodic stalling.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 200);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 1) == 1);
        2:       out_stall <= ($urandom_range(0, 9) < 8);
        default: out_stall <= (stall_left % 8 < 3);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // The sender runs in bursts; a gap opens whenever the current burst is used up.
  task automatic send_char(input logic [dttm_pkg::CharW-1:0] ch, input logic fin);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                                : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid  <= 1'b1;
    character <= ch;
    last      <= fin;
    do @(posedge clk); while (in_stall);
    sent_chars++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) begin
      send_char(text_q[i], i == text_q.size() - 1);
    end
    text_q.delete();
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) begin
      text_q.push_back(s[i]);
    end
  endtask

  task automatic push_digits(input int unsigned count);
    for (int i = 0; i < count; i++) begin
      text_q.push_back(dttm_pkg::CharZero + 8'($urandom_range(0, 9)));
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Mostly well-formed texts with random content; the rest are mutated or pure noise.
  task automatic make_text();
    int unsigned kind;
    int unsigned nfields;
    int unsigned ndig;
    int unsigned pos;
    string       charset;
    charset = "0123456789:.";
    kind    = $urandom_range(0, 9);
    if (kind < 8) begin
      nfields = $urandom_range(1, 3) + (($urandom_range(0, 9) == 0) ? 1 : 0);
      for (int f = 0; f < nfields; f++) begin
        if (f > 0) begin
          text_q.push_back(dttm_pkg::CharColon);
        end
        if ($urandom_range(0, 19) == 0) begin
          ndig = 0;
        end else if ($urandom_range(0, 9) == 0) begin
          ndig = $urandom_range(4, 7);
        end else begin
          ndig = $urandom_range(1, 3);
        end
        push_digits(ndig);
      end
      if ($urandom_range(0, 1) == 1) begin
        text_q.push_back(dttm_pkg::CharDot);
        push_digits($urandom_range(0, 5));
      end
      case ($urandom_range(0, 3))
        0: begin
          text_q.push_back(dttm_pkg::CharNul);
          for (int i = $urandom_range(0, 3); i > 0; i--) begin
            text_q.push_back(8'($urandom_range(0, 255)));
          end
        end
        1: text_q.push_back(8'($urandom_range(0, 255)));
        default: begin
        end
      endcase
      if (kind == 7 && text_q.size() > 0) begin
        pos = $urandom_range(0, text_q.size() - 1);
        if ($urandom_range(0, 1) == 1 && text_q.size() > 1) begin
          text_q.delete(pos);
        end else begin
          text_q[pos] = 8'($urandom_range(0, 255));
        end
      end
    end else begin
      for (int i = $urandom_range(1, 8); i > 0; i--) begin
        if ($urandom_range(0, 1) == 1) begin
          text_q.push_back(8'($urandom_range(0, 255)));
        end else begin
          text_q.push_back(charset[$urandom_range(0, charset.len() - 1)]);
        end
      end
    end
    if (text_q.size() == 0) begin
      text_q.push_back(dttm_pkg::CharNul);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fraction digits past the third are dropped.
    push_str("1:2:3.4567");
    send_text();
    // A stray byte in the integer part.
    text_q.push_back(8'hFF);
    send_text();
    // A third colon.
    push_str(":::");
    send_text();
    // A field that grows past the limit before another digit.
    push_str("9999999");
    send_text();
    // A zero byte closes the fraction and the trailing byte is ignored.
    push_str("5.");
    text_q.push_back(dttm_pkg::CharNul);
    push_str("x");
    send_text();
    // No digit after the final colon.
    push_str("7:");
    send_text();
    drain();

    while (sent_chars < TargetChars) begin
      make_text();
      send_text();
      if ($urandom_range(0, 39) == 0) begin
        drain();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
